>>> rtl/dqpsk_sd_pkg.sv
// Shared types and constants for the DQPSK soft demodulator.
// No dependencies; used by every module in rtl/.
package dqpsk_sd_pkg;

  localparam int OFFSET_WIDTH = 11;
  localparam int SOFT_WIDTH   = 8;
  localparam int K_BITS       = 7;    // soft magnitude 0..127

  // mode field codes
  localparam logic MODE_REF  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Per-component sidecar carried down the search stages
  typedef struct packed {
    logic              neg;  // component was negative
    logic [K_BITS-1:0] k;    // soft magnitude, built MSB first
  } lane_t;

endpackage

>>> rtl/dqpsk_soft_demodulator_core.sv
// DQPSK soft demodulator top level: reference store, differential product, search pipeline.
// Depends on dqpsk_sd_pkg and dqpsk_sd_step.
//
// Takes one carrier sample per clock while not stalled and, for a data-mode sample, presents
// one soft-bit pair through fifteen register stages: the reference store read, six for
// product, magnitude and power, seven for the bit-by-bit soft magnitude search, and the
// output register. Stages advance independently and close up bubbles, so a stalled output
// holds only the stages behind it. Input is stalled during reset. A reference-mode sample
// updates the store and leaves the pipeline after the read.
// The store needs no clearing; reading a bin never written gives an unspecified result.
// FFT_SIZE must be a power of two; the bin is the low bits of the offset.
module dqpsk_soft_demodulator_core #(
  parameter int FFT_SIZE     = 2048,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   mode,
  input  logic signed [dqpsk_sd_pkg::OFFSET_WIDTH-1:0] carrier_offset,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_im,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dqpsk_sd_pkg::SOFT_WIDTH-1:0] soft_real,
  output logic signed [dqpsk_sd_pkg::SOFT_WIDTH-1:0] soft_imag
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = $clog2(FFT_SIZE);
  localparam int DW = 2*SW+1;   // differential product component
  localparam int MW = 2*SW;     // its magnitude
  localparam int PW = 4*SW;     // power
  localparam int WT = 4*SW+16;  // search residues

  // ---------------- handshake ----------------
  logic [7:1]  vf;
  logic [7:0]  v_s;
  logic [16:1] rdy;
  logic [15:1] vall;
  logic        accept;

  assign vall[7:1]  = vf;
  assign vall[14:8] = v_s[7:1];
  assign vall[15]   = out_valid;

  always_comb begin
    rdy[16] = !out_stall;
    for (int i = 15; i >= 1; i--) begin
      rdy[i] = !vall[i] || rdy[i+1];
    end
  end

  assign in_stall = rst || !rdy[1];
  assign accept   = in_valid && !in_stall;

  // ---------------- reference store ----------------
  logic [AW-1:0]   bin;
  logic [2*SW-1:0] ref_mem [FFT_SIZE];
  logic [2*SW-1:0] ref_q;

  assign bin = carrier_offset[AW-1:0];

  // read-old, write-new in the same cycle keeps back-to-back transfers on one bin in order
  always_ff @(posedge clk) begin
    if (accept) begin
      ref_mem[bin] <= {sample_im, sample_re};
    end
    if (rdy[1]) begin
      ref_q <= ref_mem[bin];
    end
  end

  // ---------------- front stages ----------------
  logic                 m1;
  logic signed [SW-1:0] sr1, si1;
  logic signed [SW-1:0] rr, ri;
  logic signed [2*SW-1:0] pa, pb, pc, pd;
  logic signed [DW-1:0] dr, di;
  logic [MW-1:0]        ar, ai;
  logic [1:0]           neg4, neg5, neg6;
  logic [2*SW-1:0]      hh_r, hl_r, ll_r, hh_i, hl_i, ll_i;
  logic [PW-1:0]        sq_r, sq_i;

  logic [PW-1:0]        p_s [8];
  logic [WT-1:0]        r_s [8][2];
  logic [WT-1:0]        q_s [8][2];
  dqpsk_sd_pkg::lane_t  l_s [8][2];

  assign rr = ref_q[SW-1:0];
  assign ri = ref_q[2*SW-1:SW];
  assign v_s[0] = vf[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= '0;
    end else begin
      if (rdy[1]) vf[1] <= accept;
      // reference transfers end here
      if (rdy[2]) vf[2] <= vf[1] && (m1 == dqpsk_sd_pkg::MODE_DATA);
      for (int i = 3; i <= 7; i++) begin
        if (rdy[i]) vf[i] <= vf[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m1  <= mode;
      sr1 <= sample_re;
      si1 <= sample_im;
    end
    if (rdy[2]) begin
      pa <= sr1 * rr;
      pb <= si1 * ri;
      pc <= si1 * rr;
      pd <= sr1 * ri;
    end
    if (rdy[3]) begin
      dr <= DW'(pa) + DW'(pb);
      di <= DW'(pc) - DW'(pd);
    end
    if (rdy[4]) begin
      ar   <= MW'(dr[DW-1] ? -dr : dr);
      ai   <= MW'(di[DW-1] ? -di : di);
      neg4 <= {di[DW-1], dr[DW-1]};
    end
    // squares from half-width partial products
    if (rdy[5]) begin
      hh_r <= ar[MW-1:SW] * ar[MW-1:SW];
      hl_r <= ar[MW-1:SW] * ar[SW-1:0];
      ll_r <= ar[SW-1:0]  * ar[SW-1:0];
      hh_i <= ai[MW-1:SW] * ai[MW-1:SW];
      hl_i <= ai[MW-1:SW] * ai[SW-1:0];
      ll_i <= ai[SW-1:0]  * ai[SW-1:0];
      neg5 <= neg4;
    end
    if (rdy[6]) begin
      sq_r <= (PW'(hh_r) << (2*SW)) + (PW'(hl_r) << (SW+1)) + PW'(ll_r);
      sq_i <= (PW'(hh_i) << (2*SW)) + (PW'(hl_i) << (SW+1)) + PW'(ll_i);
      neg6 <= neg5;
    end
    // P = |d|^2, T = 127^2 * x^2
    if (rdy[7]) begin
      p_s[0]    <= sq_r + sq_i;
      r_s[0][0] <= (WT'(sq_r) << 14) - (WT'(sq_r) << 8) + WT'(sq_r);
      r_s[0][1] <= (WT'(sq_i) << 14) - (WT'(sq_i) << 8) + WT'(sq_i);
      q_s[0][0] <= '0;
      q_s[0][1] <= '0;
      l_s[0][0] <= '{neg: neg6[0], k: '0};
      l_s[0][1] <= '{neg: neg6[1], k: '0};
    end
  end

  // ---------------- soft magnitude search ----------------
  for (genvar j = 0; j < dqpsk_sd_pkg::K_BITS; j++) begin : g_step
    dqpsk_sd_step #(
      .SW  (SW),
      .BIT (dqpsk_sd_pkg::K_BITS-1-j)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (rdy[8+j]),
      .v_in     (v_s[j]),
      .p_in     (p_s[j]),
      .r_in     (r_s[j]),
      .q_in     (q_s[j]),
      .lane_in  (l_s[j]),
      .v_out    (v_s[j+1]),
      .p_out    (p_s[j+1]),
      .r_out    (r_s[j+1]),
      .q_out    (q_s[j+1]),
      .lane_out (l_s[j+1])
    );
  end

  // ---------------- output register ----------------
  logic [dqpsk_sd_pkg::SOFT_WIDTH-1:0] kr, ki;
  logic                                zero_pw;

  assign kr      = {1'b0, l_s[7][0].k};
  assign ki      = {1'b0, l_s[7][1].k};
  assign zero_pw = (p_s[7] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[15]) begin
      out_valid <= v_s[7];
    end
  end

  // positive component gives a negative soft bit; zero power gives zero
  always_ff @(posedge clk) begin
    if (rdy[15]) begin
      soft_real <= zero_pw ? '0 : (l_s[7][0].neg ? kr : -kr);
      soft_imag <= zero_pw ? '0 : (l_s[7][1].neg ? ki : -ki);
    end
  end

endmodule

>>> rtl/dqpsk_sd_step.sv
// One bit of the soft-magnitude search, both components side by side.
// Depends on dqpsk_sd_pkg.
module dqpsk_sd_step #(
  parameter int SW  = 16,
  parameter int BIT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [4*SW-1:0]        p_in,
  input  logic [4*SW+15:0]       r_in [2],
  input  logic [4*SW+15:0]       q_in [2],
  input  dqpsk_sd_pkg::lane_t    lane_in [2],
  output logic                   v_out,
  output logic [4*SW-1:0]        p_out,
  output logic [4*SW+15:0]       r_out [2],
  output logic [4*SW+15:0]       q_out [2],
  output dqpsk_sd_pkg::lane_t    lane_out [2]
);

  localparam int WT = 4*SW+16;

  logic [WT-1:0]       p_ext;
  logic [WT-1:0]       term [2];
  logic [1:0]          fit;
  logic [WT-1:0]       r_next [2];
  logic [WT-1:0]       q_next [2];
  dqpsk_sd_pkg::lane_t lane_next [2];

  // R holds T - k^2*P, Q holds k*P; trying k + 2^BIT costs (Q<<(BIT+1)) + (P<<2*BIT)
  always_comb begin
    p_ext = WT'(p_in);
    for (int i = 0; i < 2; i++) begin
      term[i]      = (q_in[i] << (BIT+1)) + (p_ext << (2*BIT));
      fit[i]       = term[i] <= r_in[i];
      r_next[i]    = fit[i] ? r_in[i] - term[i] : r_in[i];
      q_next[i]    = fit[i] ? q_in[i] + (p_ext << BIT) : q_in[i];
      lane_next[i] = lane_in[i];
      lane_next[i].k[BIT] = fit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= p_in;
      for (int i = 0; i < 2; i++) begin
        r_out[i]    <= r_next[i];
        q_out[i]    <= q_next[i];
        lane_out[i] <= lane_next[i];
      end
    end
  end

endmodule
